[src/cfr_pkg.sv]
// Shared types, constants and helper functions of the command frame receiver.
package cfr_pkg;

   localparam int STORE_DEPTH = 32;
   localparam int ADDR_W      = 5;
   localparam int LEN_W       = 6;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [LEN_W-1:0]  len_type;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   // Magnitude bits of 180.0f and of an all-ones exponent
   localparam logic [30:0] POS_LIMIT_MAG = 31'h43340000;
   localparam logic [30:0] EXP_ONES_MAG  = 31'h7F800000;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_HEADER  = 3'd0;
   localparam logic [2:0] CSR_FOOTER  = 3'd1;
   localparam logic [2:0] CSR_MOTION  = 3'd2;
   localparam logic [2:0] CSR_QUERY   = 3'd3;
   localparam logic [2:0] CSR_GRIPPER = 3'd4;
   localparam logic [2:0] CSR_ENABLE  = 3'd5;
   localparam logic [2:0] CSR_DISABLE = 3'd6;

   typedef enum logic [2:0] {
      KIND_MOTION  = 3'd0,
      KIND_QUERY   = 3'd1,
      KIND_GRIPPER = 3'd2,
      KIND_ENABLE  = 3'd3,
      KIND_DISABLE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CRC_ERR   = 2'd1,
      STATUS_RANGE_ERR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] hdr_byte;
      logic [7:0] ftr_byte;
      logic [7:0] motion_code;
      logic [7:0] query_code;
      logic [7:0] gripper_code;
      logic [7:0] enable_code;
      logic [7:0] disable_code;
   } cfg_type;

   typedef struct packed {
      logic       en;
      addr_type   addr;
      logic [7:0] data;
   } store_wr_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
      len_type  len;
   } frame_done_type;

   // CRC16, MSB first, over one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // Outside [-180, 180]; NaN passes, infinity fails
   function automatic logic joint_out_of_range(input logic [31:0] bits);
      return (bits[30:0] <= EXP_ONES_MAG) && (bits[30:0] > POS_LIMIT_MAG);
   endfunction

endpackage

[src/cfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/cfr_rx.sv]
// Byte intake: header hunt, byte counting, command classification and store writes.
module cfr_rx #(
   parameter int MOTION_FRAME_BYTES = 29,
   parameter int SIMPLE_FRAME_BYTES = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              rx_byte,
   input  cfr_pkg::cfg_type        cfg,
   output cfr_pkg::store_wr_type   wr,
   output cfr_pkg::frame_done_type done
);

   localparam cfr_pkg::len_type MOTION_LEN  = cfr_pkg::len_type'(MOTION_FRAME_BYTES);
   localparam cfr_pkg::len_type SIMPLE_LEN  = cfr_pkg::len_type'(SIMPLE_FRAME_BYTES);
   localparam cfr_pkg::len_type CMD_POS     = cfr_pkg::len_type'(1);
   localparam cfr_pkg::len_type CLASSIFY_AT = cfr_pkg::len_type'(3);

   logic             in_frame_ff, in_frame_in;
   cfr_pkg::len_type count_ff, count_in;
   logic [7:0]       cmd_ff, cmd_in;

   cfr_pkg::len_type  count_next;
   logic              known;
   cfr_pkg::kind_type kind;
   cfr_pkg::len_type  len;

   // First match wins when codes are shared
   always_comb begin
      known = 1'b1;
      kind  = cfr_pkg::KIND_MOTION;
      len   = MOTION_LEN;
      if (cmd_ff == cfg.motion_code) begin
         kind = cfr_pkg::KIND_MOTION;
         len  = MOTION_LEN;
      end else if (cmd_ff == cfg.query_code) begin
         kind = cfr_pkg::KIND_QUERY;
         len  = SIMPLE_LEN;
      end else if (cmd_ff == cfg.gripper_code) begin
         kind = cfr_pkg::KIND_GRIPPER;
         len  = SIMPLE_LEN;
      end else if (cmd_ff == cfg.enable_code) begin
         kind = cfr_pkg::KIND_ENABLE;
         len  = SIMPLE_LEN;
      end else if (cmd_ff == cfg.disable_code) begin
         kind = cfr_pkg::KIND_DISABLE;
         len  = SIMPLE_LEN;
      end else begin
         known = 1'b0;
      end
   end

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      count_next  = count_ff + cfr_pkg::len_type'(1);
      wr          = '0;
      done        = '0;
      done.kind   = kind;
      done.len    = len;
      if (accept) begin
         if (!in_frame_ff) begin
            if (rx_byte == cfg.hdr_byte) begin
               wr.en       = 1'b1;
               wr.addr     = '0;
               wr.data     = rx_byte;
               count_in    = cfr_pkg::len_type'(1);
               in_frame_in = 1'b1;
            end
         end else begin
            wr.en   = 1'b1;
            wr.addr = count_ff[cfr_pkg::ADDR_W-1:0];
            wr.data = rx_byte;
            if (count_ff == CMD_POS) begin
               cmd_in = rx_byte;
            end
            if (count_next < CLASSIFY_AT) begin
               count_in = count_next;
            end else if (!known) begin
               // unknown command: drop the frame
               in_frame_in = 1'b0;
               count_in    = '0;
            end else if (count_next < len) begin
               count_in = count_next;
            end else begin
               in_frame_in = 1'b0;
               count_in    = '0;
               done.valid  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

[src/cfr_check.sv]
// Frame checker: walks the frame store for footer, CRC and joint checks, drives results.
module cfr_check #(
   parameter int JOINT_COUNT = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cfr_pkg::frame_done_type done,
   input  cfr_pkg::cfg_type        cfg,
   output cfr_pkg::addr_type       rd_addr,
   input  logic [7:0]              rd_data,
   output logic                    busy,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_command_kind,
   output logic [1:0]              rsp_status,
   output logic [2:0]              rsp_joint_index,
   output logic [31:0]             rsp_value,
   output logic                    rsp_last
);

   localparam cfr_pkg::len_type JOINT_BYTES = cfr_pkg::len_type'(4 * JOINT_COUNT);
   localparam cfr_pkg::len_type JOINT_BASE  = cfr_pkg::len_type'(2);
   localparam cfr_pkg::len_type CKSUM_TAIL  = cfr_pkg::len_type'(3);
   localparam cfr_pkg::len_type ONE         = cfr_pkg::len_type'(1);
   localparam cfr_pkg::addr_type GRIP_POS   = cfr_pkg::addr_type'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOOT_RD,
      ST_FOOT_CHK,
      ST_ACK,
      ST_CRC,
      ST_VERDICT,
      ST_GRIP_RD,
      ST_GRIP_OUT,
      ST_SCAN,
      ST_FAIL,
      ST_EMIT,
      ST_EMIT_OUT
   } state_type;

   state_type           state_ff, state_in;
   cfr_pkg::kind_type   kind_ff, kind_in;
   cfr_pkg::len_type    len_ff, len_in;
   cfr_pkg::len_type    cnt_ff, cnt_in;
   logic                dv_ff, dv_in;
   logic [15:0]         crc_ff, crc_in;
   logic [15:0]         sum_ff, sum_in;
   logic [31:0]         word_ff, word_in;
   logic [2:0]          joint_ff, joint_in;
   logic                last_ff, last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   cfr_pkg::kind_type     rsp_kind_ff, rsp_kind_in;
   cfr_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [2:0]            rsp_joint_ff, rsp_joint_in;
   logic [31:0]           rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;

   cfr_pkg::len_type d_addr;
   cfr_pkg::len_type foot_addr;
   cfr_pkg::len_type joint_addr;
   cfr_pkg::len_type crc_end;
   logic [31:0]      word_full;
   logic             out_free;

   assign d_addr     = cnt_ff - ONE;
   assign foot_addr  = len_ff - ONE;
   assign joint_addr = cnt_ff + JOINT_BASE;
   assign crc_end    = len_ff - CKSUM_TAIL;
   assign word_full  = {rd_data, word_ff[31:8]};
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (state_ff)
         ST_FOOT_RD:                rd_addr = foot_addr[cfr_pkg::ADDR_W-1:0];
         ST_CRC:                    rd_addr = cnt_ff[cfr_pkg::ADDR_W-1:0];
         ST_SCAN, ST_EMIT:          rd_addr = joint_addr[cfr_pkg::ADDR_W-1:0];
         ST_GRIP_RD, ST_GRIP_OUT:   rd_addr = GRIP_POS;
         default:                   rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      dv_in         = 1'b0;
      crc_in        = crc_ff;
      sum_in        = sum_ff;
      word_in       = word_ff;
      joint_in      = joint_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_joint_in  = rsp_joint_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (done.valid) begin
               kind_in  = done.kind;
               len_in   = done.len;
               state_in = ST_FOOT_RD;
            end
         end

         ST_FOOT_RD: begin
            state_in = ST_FOOT_CHK;
         end

         ST_FOOT_CHK: begin
            if (rd_data != cfg.ftr_byte) begin
               state_in = ST_IDLE;
            end else if (kind_ff == cfr_pkg::KIND_ENABLE ||
                         kind_ff == cfr_pkg::KIND_DISABLE) begin
               state_in = ST_ACK;
            end else begin
               crc_in   = cfr_pkg::CRC_INIT;
               cnt_in   = '0;
               state_in = ST_CRC;
            end
         end

         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_status_in = cfr_pkg::STATUS_OK;
               rsp_joint_in  = '0;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_CRC: begin
            // issue one read a cycle; data trails the address through the RAM's registered read port
            cnt_in = cnt_ff + ONE;
            dv_in  = 1'b1;
            if (dv_ff) begin
               if (d_addr < crc_end) begin
                  crc_in = cfr_pkg::crc16_byte(crc_ff, rd_data);
               end else if (d_addr == crc_end) begin
                  sum_in[7:0] = rd_data;
               end else begin
                  sum_in[15:8] = rd_data;
                  dv_in        = 1'b0;
                  state_in     = ST_VERDICT;
               end
            end
         end

         ST_VERDICT: begin
            if (crc_ff != sum_ff) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = kind_ff;
                  rsp_status_in = cfr_pkg::STATUS_CRC_ERR;
                  rsp_joint_in  = '0;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (kind_ff == cfr_pkg::KIND_QUERY) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = kind_ff;
                  rsp_status_in = cfr_pkg::STATUS_OK;
                  rsp_joint_in  = '0;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (kind_ff == cfr_pkg::KIND_GRIPPER) begin
               state_in = ST_GRIP_RD;
            end else begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_GRIP_RD: begin
            state_in = ST_GRIP_OUT;
         end

         ST_GRIP_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_status_in = cfr_pkg::STATUS_OK;
               rsp_joint_in  = '0;
               rsp_value_in  = {24'h000000, rd_data};
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_SCAN: begin
            cnt_in = cnt_ff + ONE;
            dv_in  = 1'b1;
            if (dv_ff) begin
               word_in = word_full;
               if (d_addr[1:0] == 2'd3) begin
                  if (cfr_pkg::joint_out_of_range(word_full)) begin
                     joint_in = d_addr[4:2];
                     dv_in    = 1'b0;
                     state_in = ST_FAIL;
                  end else if (d_addr == JOINT_BYTES - ONE) begin
                     cnt_in   = '0;
                     dv_in    = 1'b0;
                     state_in = ST_EMIT;
                  end
               end
            end
         end

         ST_FAIL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_status_in = cfr_pkg::STATUS_RANGE_ERR;
               rsp_joint_in  = joint_ff;
               rsp_value_in  = word_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_EMIT: begin
            cnt_in = cnt_ff + ONE;
            dv_in  = 1'b1;
            if (dv_ff) begin
               word_in = word_full;
               if (d_addr[1:0] == 2'd3) begin
                  // hold the count so the next joint's first byte is read again
                  joint_in = d_addr[4:2];
                  last_in  = (d_addr == JOINT_BYTES - ONE);
                  cnt_in   = cnt_ff;
                  dv_in    = 1'b0;
                  state_in = ST_EMIT_OUT;
               end
            end
         end

         ST_EMIT_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = kind_ff;
               rsp_status_in = cfr_pkg::STATUS_OK;
               rsp_joint_in  = joint_ff;
               rsp_value_in  = word_ff;
               rsp_last_in   = last_ff;
               state_in      = last_ff ? ST_IDLE : ST_EMIT;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dv_ff        <= 1'b0;
         crc_ff       <= cfr_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dv_ff        <= dv_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      len_ff        <= len_in;
      cnt_ff        <= cnt_in;
      sum_ff        <= sum_in;
      word_ff       <= word_in;
      joint_ff      <= joint_in;
      last_ff       <= last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_joint_ff  <= rsp_joint_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = rsp_kind_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_joint_index  = rsp_joint_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[src/command_frame_receiver_crc16.sv]
// Top level of the command frame receiver with CRC16 frame check.
//
// Accepts one received byte per beat on the req_ channel, one beat per cycle while a frame
// is being hunted for or collected; every byte of a frame goes into a 32-entry frame store
// RAM. When the last byte of a frame arrives, req_ready drops and the checker walks the
// store through the RAM's single registered read port: first the footer, then for all but
// enable and disable the CRC16 (poly 0x1021, init 0xFFFF) and the little-endian checksum,
// then one result for query, gripper, enable, disable or a CRC error, and for a motion
// frame a range scan followed by one result per joint or a single range error result.
// Results leave through an output register and wait on rsp_ready, so the next frame's
// bytes are taken while the final result beat still waits. Dropped frames (unknown
// command, bad footer) give no result. The frame store is never cleared; bytes are
// always written within a frame before being read.
module command_frame_receiver_crc16 #(
   parameter int MOTION_FRAME_BYTES = 29,
   parameter int SIMPLE_FRAME_BYTES = 6,
   parameter int JOINT_COUNT        = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_command_kind,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_joint_index,
   output logic [31:0] rsp_value,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfr_pkg::cfg_type        cfg_ff, cfg_in;
   cfr_pkg::store_wr_type   store_wr;
   cfr_pkg::frame_done_type frame_done;
   cfr_pkg::addr_type       store_rd_addr;
   logic [7:0]              store_rd_data;
   logic                    check_busy;
   logic                    req_accept;

   // Decode configuration writes; an index past the list is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            cfr_pkg::CSR_HEADER:  cfg_in.hdr_byte     = csr_wdata;
            cfr_pkg::CSR_FOOTER:  cfg_in.ftr_byte     = csr_wdata;
            cfr_pkg::CSR_MOTION:  cfg_in.motion_code  = csr_wdata;
            cfr_pkg::CSR_QUERY:   cfg_in.query_code   = csr_wdata;
            cfr_pkg::CSR_GRIPPER: cfg_in.gripper_code = csr_wdata;
            cfr_pkg::CSR_ENABLE:  cfg_in.enable_code  = csr_wdata;
            cfr_pkg::CSR_DISABLE: cfg_in.disable_code = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Take bytes only while the checker is not walking a finished frame
   assign req_ready  = !check_busy;
   assign req_accept = req_valid && req_ready;

   cfr_rx #(
      .MOTION_FRAME_BYTES(MOTION_FRAME_BYTES),
      .SIMPLE_FRAME_BYTES(SIMPLE_FRAME_BYTES)
   ) u_rx (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .wr      (store_wr),
      .done    (frame_done)
   );

   cfr_ram #(
      .WIDTH(8),
      .DEPTH(cfr_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   cfr_check #(
      .JOINT_COUNT(JOINT_COUNT)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .done             (frame_done),
      .cfg              (cfg_ff),
      .rd_addr          (store_rd_addr),
      .rd_data          (store_rd_data),
      .busy             (check_busy),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_command_kind (rsp_command_kind),
      .rsp_status       (rsp_status),
      .rsp_joint_index  (rsp_joint_index),
      .rsp_value        (rsp_value),
      .rsp_last         (rsp_last)
   );

endmodule

[tb/command_frame_receiver_crc16_tb.sv]
// Self-checking testbench of the command frame receiver: byte predictor, framed stimulus, stalls.
module command_frame_receiver_crc16_tb;

   localparam int MOTION_BYTES = 29;
   localparam int SIMPLE_BYTES = 6;
   localparam int JOINTS       = 6;

   // Cycles to let pass after the last result before touching the registers or ending:
   // covers a motion frame scan plus the footer check of a dropped frame.
   localparam int SETTLE_CYCLES = 120;
   // Cycles without any beat while work is outstanding before giving up
   localparam int STALL_LIMIT   = 4000;

   // Magnitudes of the limit (180.0f) and of infinity, used to build joint stimulus
   localparam logic [30:0] LIMIT_MAG = 31'h43340000;
   localparam logic [30:0] INF_MAG   = 31'h7F800000;

   typedef enum int {FLAW_NONE, FLAW_CRC, FLAW_FOOTER, FLAW_CMD} frame_flaw_type;

   typedef struct packed {
      cfr_pkg::kind_type   kind;
      cfr_pkg::status_type status;
      logic [2:0]          joint;
      logic [31:0]         value;
      logic                last;
   } frame_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_command_kind;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_joint_index;
   logic [31:0] rsp_value;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = 3'd0;
   logic [7:0]  csr_wdata = 8'h00;

   command_frame_receiver_crc16 #(
      .MOTION_FRAME_BYTES(MOTION_BYTES),
      .SIMPLE_FRAME_BYTES(SIMPLE_BYTES),
      .JOINT_COUNT(JOINTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_command_kind(rsp_command_kind),
      .rsp_status(rsp_status),
      .rsp_joint_index(rsp_joint_index),
      .rsp_value(rsp_value),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Receiver shadow: register copy, frame state and expected results
   // ------------------------------------------------------------------
   cfr_pkg::cfg_type  active_cfg = '0;
   logic              shadow_open = 1'b0;
   logic [5:0]        rx_count = 6'd0;
   logic [7:0]        rx_store [32];
   frame_result_type  expected_results [$];

   logic [7:0]     byte_backlog [$];    // bytes waiting for the driver
   int             frame_bytes  = 0;    // framed bytes queued (noise excluded)
   int             mismatches   = 0;
   int             req_beats    = 0;
   int             rsp_beats    = 0;

   // CRC16, poly 0x1021, MSB first: advance by one byte
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // First match in the order motion, query, gripper, enable, disable; -1 when unknown
   function automatic int kind_of_cmd(input logic [7:0] cmd);
      if (cmd == active_cfg.motion_code)  return cfr_pkg::KIND_MOTION;
      if (cmd == active_cfg.query_code)   return cfr_pkg::KIND_QUERY;
      if (cmd == active_cfg.gripper_code) return cfr_pkg::KIND_GRIPPER;
      if (cmd == active_cfg.enable_code)  return cfr_pkg::KIND_ENABLE;
      if (cmd == active_cfg.disable_code) return cfr_pkg::KIND_DISABLE;
      return -1;
   endfunction

   function automatic void note_result(input cfr_pkg::kind_type k, input cfr_pkg::status_type s,
                                       input int j, input logic [31:0] v, input logic l);
      frame_result_type r;
      r = '{kind: k, status: s, joint: j[2:0], value: v, last: l};
      expected_results.push_back(r);
   endfunction

   function automatic logic [31:0] stored_joint(input int j);
      int base;
      base = 2 + 4 * j;
      return {rx_store[(base + 3) % 32], rx_store[(base + 2) % 32],
              rx_store[(base + 1) % 32], rx_store[base % 32]};
   endfunction

   // Advance the shadow by one accepted byte and queue whatever results it completes
   function automatic void absorb_byte(input logic [7:0] b);
      int                code;
      cfr_pkg::kind_type k;
      int                len;
      logic [15:0]       crc;
      logic [31:0]       bits;
      if (!shadow_open) begin
         // hunt: drop everything but the header
         if (b == active_cfg.hdr_byte) begin
            rx_store[0] = b;
            rx_count    = 6'd1;
            shadow_open = 1'b1;
         end
         return;
      end
      rx_store[rx_count[4:0]] = b;
      rx_count = rx_count + 6'd1;
      if (rx_count < 3) return;
      code = kind_of_cmd(rx_store[1]);
      if (code < 0) begin
         // unknown command: drop on the third byte, which is never a new header
         shadow_open = 1'b0;
         rx_count    = 6'd0;
         return;
      end
      k   = cfr_pkg::kind_type'(code);
      len = (k == cfr_pkg::KIND_MOTION) ? MOTION_BYTES : SIMPLE_BYTES;
      if (rx_count < len) return;
      shadow_open = 1'b0;
      rx_count    = 6'd0;
      if (rx_store[(len - 1) % 32] != active_cfg.ftr_byte) return;
      if (k == cfr_pkg::KIND_ENABLE || k == cfr_pkg::KIND_DISABLE) begin
         note_result(k, cfr_pkg::STATUS_OK, 0, 32'h0, 1'b1);
         return;
      end
      crc = 16'hFFFF;
      for (int i = 0; i < len - 3; i++) crc = crc16_step(crc, rx_store[i % 32]);
      if (crc != {rx_store[(len - 2) % 32], rx_store[(len - 3) % 32]}) begin
         note_result(k, cfr_pkg::STATUS_CRC_ERR, 0, 32'h0, 1'b1);
         return;
      end
      if (k == cfr_pkg::KIND_QUERY) begin
         note_result(k, cfr_pkg::STATUS_OK, 0, 32'h0, 1'b1);
         return;
      end
      if (k == cfr_pkg::KIND_GRIPPER) begin
         note_result(k, cfr_pkg::STATUS_OK, 0, {24'h0, rx_store[2]}, 1'b1);
         return;
      end
      // motion: the first joint past +-180 (infinity included, NaN excluded) fails the frame
      for (int j = 0; j < JOINTS; j++) begin
         bits = stored_joint(j);
         if (bits[30:0] <= INF_MAG && bits[30:0] > LIMIT_MAG) begin
            note_result(k, cfr_pkg::STATUS_RANGE_ERR, j, bits, 1'b1);
            return;
         end
      end
      for (int j = 0; j < JOINTS; j++)
         note_result(k, cfr_pkg::STATUS_OK, j, stored_joint(j), j == JOINTS - 1);
   endfunction

   // ------------------------------------------------------------------
   // Frame building
   // ------------------------------------------------------------------
   function automatic logic [7:0] code_for(input cfr_pkg::kind_type k);
      case (k)
         cfr_pkg::KIND_MOTION:  return active_cfg.motion_code;
         cfr_pkg::KIND_QUERY:   return active_cfg.query_code;
         cfr_pkg::KIND_GRIPPER: return active_cfg.gripper_code;
         cfr_pkg::KIND_ENABLE:  return active_cfg.enable_code;
         default:               return active_cfg.disable_code;
      endcase
   endfunction

   // Queue one frame of kind k; its length follows the kind the receiver decodes from the
   // command byte, so shared codes still give aligned frames.
   function automatic void push_frame(input cfr_pkg::kind_type k, input frame_flaw_type flaw,
                                      input logic [7:0] param, input logic [31:0] joints [JOINTS]);
      logic [7:0]  fr [$];
      logic [7:0]  cmd;
      logic [15:0] crc;
      int          len;
      cmd = code_for(k);
      fr.push_back(active_cfg.hdr_byte);
      if (flaw == FLAW_CMD) begin
         do cmd = 8'($urandom); while (kind_of_cmd(cmd) >= 0);
         fr.push_back(cmd);
         fr.push_back(param);
      end else begin
         len = (kind_of_cmd(cmd) == cfr_pkg::KIND_MOTION) ? MOTION_BYTES : SIMPLE_BYTES;
         fr.push_back(cmd);
         if (len == MOTION_BYTES) begin
            for (int j = 0; j < JOINTS; j++)
               for (int i = 0; i < 4; i++) fr.push_back(joints[j][8*i +: 8]);
         end else begin
            fr.push_back(param);
         end
         while (fr.size() < len - 3) fr.push_back(8'($urandom));
         crc = 16'hFFFF;
         foreach (fr[i]) crc = crc16_step(crc, fr[i]);
         if (flaw == FLAW_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
         fr.push_back(crc[7:0]);
         fr.push_back(crc[15:8]);
         fr.push_back((flaw == FLAW_FOOTER) ?
                      active_cfg.ftr_byte ^ 8'($urandom_range(1, 255)) : active_cfg.ftr_byte);
      end
      foreach (fr[i]) byte_backlog.push_back(fr[i]);
      frame_bytes += fr.size();
   endfunction

   // Mostly in-range positions; now and then the limit, just past it, infinity, NaN or random bits
   function automatic logic [31:0] draw_joint();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return {1'($urandom), 31'($urandom_range(0, 32'h43340000))};
      case (r % 5)
         0: return {1'($urandom), LIMIT_MAG + 31'($urandom_range(1, 3))};
         1: return {1'($urandom), INF_MAG};
         2: return {1'($urandom), INF_MAG | 31'($urandom_range(1, 32'h007FFFFF))};
         3: return $urandom;
         default: return {1'($urandom), LIMIT_MAG};
      endcase
   endfunction

   function automatic void random_frames(input int count);
      logic [31:0]    js [JOINTS];
      logic [7:0]     nb;
      int unsigned    r;
      frame_flaw_type flaw;
      for (int n = 0; n < count; n++) begin
         // idle-line noise between frames, never a header byte; the receiver ignores it while hunting
         if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 4)) begin
               do nb = 8'($urandom); while (nb == active_cfg.hdr_byte);
               byte_backlog.push_back(nb);
            end
         end
         r = $urandom_range(0, 99);
         if (r >= 95) begin
            // broken sequence: a header followed by junk
            byte_backlog.push_back(active_cfg.hdr_byte);
            repeat ($urandom_range(1, 5)) byte_backlog.push_back(8'($urandom));
            frame_bytes += 3;
         end else begin
            flaw = (r < 70) ? FLAW_NONE : (r < 80) ? FLAW_CRC : (r < 88) ? FLAW_FOOTER : FLAW_CMD;
            foreach (js[j]) js[j] = draw_joint();
            push_frame(cfr_pkg::kind_type'($urandom_range(0, 4)), flaw, 8'($urandom), js);
         end
      end
   endfunction

   function automatic cfr_pkg::cfg_type setting_for(input int phase);
      cfr_pkg::cfg_type s;
      case (phase)
         0: s = '{hdr_byte: 8'h00, ftr_byte: 8'hFF, motion_code: 8'hFF, query_code: 8'h00,
                  gripper_code: 8'h7F, enable_code: 8'h80, disable_code: 8'h01};
         1: s = '{hdr_byte: 8'hFF, ftr_byte: 8'h00, motion_code: 8'h00, query_code: 8'hFF,
                  gripper_code: 8'h80, enable_code: 8'h7F, disable_code: 8'hFE};
         default: s = '{hdr_byte: 8'($urandom), ftr_byte: 8'($urandom),
                        motion_code: 8'($urandom), query_code: 8'($urandom),
                        gripper_code: 8'($urandom), enable_code: 8'($urandom),
                        disable_code: 8'($urandom)};
      endcase
      return s;
   endfunction

   // Random pause length: mostly none, some short, a few long; now and then a calm stretch
   function automatic int unsigned draw_pause(inout int unsigned calm, input int unsigned zero_pct);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(30, 150);
         return 0;
      end
      if (r < zero_pct) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(12, 70);
   endfunction

   function automatic string describe(input frame_result_type r);
      return $sformatf("kind %0d status %0d joint %0d value %h last %b",
                       r.kind, r.status, r.joint, r.value, r.last);
   endfunction

   // ------------------------------------------------------------------
   // Register access and phase sequencing
   // ------------------------------------------------------------------
   task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Write every register; the receiver is idle, so update the shadow copy at once
   task automatic apply_setting(input cfr_pkg::cfg_type s);
      write_reg(cfr_pkg::CSR_HEADER,  s.hdr_byte);
      write_reg(cfr_pkg::CSR_FOOTER,  s.ftr_byte);
      write_reg(cfr_pkg::CSR_MOTION,  s.motion_code);
      write_reg(cfr_pkg::CSR_QUERY,   s.query_code);
      write_reg(cfr_pkg::CSR_GRIPPER, s.gripper_code);
      write_reg(cfr_pkg::CSR_ENABLE,  s.enable_code);
      write_reg(cfr_pkg::CSR_DISABLE, s.disable_code);
      active_cfg = s;
   endtask

   // Sample on the falling edge, where the queues and the handshake are stable
   task automatic wait_drained();
      while (byte_backlog.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   // Drain, close any frame still open with filler bytes, then let the receiver go quiet
   task automatic settle();
      wait_drained();
      while (shadow_open) begin
         byte_backlog.push_back(8'($urandom));
         wait_drained();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Input driver: one byte per beat from the backlog, random gaps between beats
   // ------------------------------------------------------------------
   int unsigned req_gap  = 0;
   int unsigned req_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_byte(req_rx_byte);
            req_beats++;
         end
         // hold valid and the byte while the beat is not taken
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (byte_backlog.size() != 0) begin
               req_rx_byte <= byte_backlog.pop_front();
               req_valid   <= 1'b1;
               req_gap     = draw_pause(req_calm, 55);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // ------------------------------------------------------------------
   int unsigned rsp_stall = 0;
   int unsigned rsp_calm  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_stall = draw_pause(rsp_calm, 88);
      end
   end

   always @(posedge clock) begin : result_check
      frame_result_type got;
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{kind: cfr_pkg::kind_type'(rsp_command_kind),
                 status: cfr_pkg::status_type'(rsp_status),
                 joint: rsp_joint_index, value: rsp_value, last: rsp_last};
         rsp_beats++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %s", describe(got));
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %s, got %s", describe(want), describe(got));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: no beat on either channel for too long while work is outstanding
   // ------------------------------------------------------------------
   int idle_run  = 0;
   int last_req  = 0;
   int last_rsp  = 0;

   always @(negedge clock) begin
      if (reset || req_beats != last_req || rsp_beats != last_rsp ||
          (byte_backlog.size() == 0 && !req_valid && expected_results.size() == 0))
         idle_run = 0;
      else
         idle_run++;
      last_req = req_beats;
      last_rsp = rsp_beats;
      if (idle_run >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results outstanding",
                  idle_run, expected_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      logic [31:0] js [JOINTS];
      logic [31:0] calm_js [JOINTS];
      int          phase;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part: distinct codes
      apply_setting('{hdr_byte: 8'hA5, ftr_byte: 8'h5A, motion_code: 8'h01, query_code: 8'h02,
                      gripper_code: 8'h03, enable_code: 8'h04, disable_code: 8'h05});
      calm_js = '{32'h3F800000, 32'hBF800000, 32'h42B40000, 32'h00000000,
                  32'h80000000, 32'hC2340000};
      // line noise while hunting
      byte_backlog.push_back(8'h00);
      byte_backlog.push_back(8'hFF);
      byte_backlog.push_back(8'h5A);
      // both limits, the smallest and a negative NaN, signed zero and a denormal pass
      js = '{32'h43340000, 32'hC3340000, 32'h7F800001, 32'hFFFFFFFF, 32'h80000000, 32'h00000001};
      push_frame(cfr_pkg::KIND_MOTION, FLAW_NONE, 8'h00, js);
      // just past +180 on joint two; the later plus infinity must not be reported
      js = calm_js;
      js[2] = 32'h43340001;
      js[4] = 32'h7F800000;
      push_frame(cfr_pkg::KIND_MOTION, FLAW_NONE, 8'h00, js);
      // minus infinity on the last joint
      js = calm_js;
      js[5] = 32'hFF800000;
      push_frame(cfr_pkg::KIND_MOTION, FLAW_NONE, 8'h00, js);
      push_frame(cfr_pkg::KIND_MOTION, FLAW_CRC, 8'h00, calm_js);
      push_frame(cfr_pkg::KIND_QUERY, FLAW_NONE, 8'h77, calm_js);
      push_frame(cfr_pkg::KIND_QUERY, FLAW_CRC, 8'h77, calm_js);
      push_frame(cfr_pkg::KIND_GRIPPER, FLAW_NONE, 8'hFF, calm_js);
      push_frame(cfr_pkg::KIND_GRIPPER, FLAW_NONE, 8'h00, calm_js);
      push_frame(cfr_pkg::KIND_GRIPPER, FLAW_CRC, 8'h3C, calm_js);
      push_frame(cfr_pkg::KIND_GRIPPER, FLAW_FOOTER, 8'h3C, calm_js);
      // enable and disable are acked whatever the checksum holds
      push_frame(cfr_pkg::KIND_ENABLE, FLAW_NONE, 8'h00, calm_js);
      push_frame(cfr_pkg::KIND_ENABLE, FLAW_CRC, 8'h00, calm_js);
      push_frame(cfr_pkg::KIND_DISABLE, FLAW_NONE, 8'hFF, calm_js);
      push_frame(cfr_pkg::KIND_DISABLE, FLAW_CRC, 8'hFF, calm_js);
      // unknown command whose third byte is a header: it is dropped, not taken as a start
      push_frame(cfr_pkg::KIND_QUERY, FLAW_CMD, 8'hA5, calm_js);
      push_frame(cfr_pkg::KIND_QUERY, FLAW_NONE, 8'h00, calm_js);
      settle();

      // Shared codes: the first match in the decode order wins
      apply_setting('{hdr_byte: 8'h00, ftr_byte: 8'hFF, motion_code: 8'h10, query_code: 8'h20,
                      gripper_code: 8'h20, enable_code: 8'h20, disable_code: 8'h10});
      push_frame(cfr_pkg::KIND_DISABLE, FLAW_NONE, 8'h00, calm_js);
      push_frame(cfr_pkg::KIND_GRIPPER, FLAW_NONE, 8'h99, calm_js);
      push_frame(cfr_pkg::KIND_ENABLE, FLAW_CRC, 8'h00, calm_js);
      settle();

      // Random part: new setting per phase, extremes first, until the byte budget is spent
      phase = 0;
      while (frame_bytes < 250) begin
         apply_setting(setting_for(phase));
         random_frames(3);
         settle();
         phase++;
      end

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
src/cfr_pkg.sv
src/cfr_ram.sv
src/cfr_rx.sv
src/cfr_check.sv
src/command_frame_receiver_crc16.sv
tb/command_frame_receiver_crc16_tb.sv
